@@ rtl/fli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fli_pkg
// Shared types and constants for the frame chunk decoder.
// ----------------------------------------------------------------------------
package fli_pkg;

   localparam int FRAME_WIDTH_DEF  = 320;
   localparam int FRAME_HEIGHT_DEF = 200;

   typedef enum logic [4:0] {
      PH_FSIZE, PH_FTYPE, PH_FCHUNKS, PH_FPAD, PH_CSIZE, PH_CTYPE,
      PH_COL_NPKT, PH_COL_SKIP, PH_COL_CNT, PH_COL_R, PH_COL_G, PH_COL_B,
      PH_DL_START, PH_DL_NLINES, PH_DL_LPKTS, PH_DL_SKIP, PH_DL_COUNT,
      PH_DL_LIT, PH_DL_COLOR, PH_BR_LPKTS, PH_BR_COUNT, PH_BR_COLOR,
      PH_BR_LIT, PH_RAW, PH_CSKIP, PH_FSKIP
   } phase_type;

   typedef enum logic [2:0] {
      KIND_OTHER, KIND_COL64, KIND_COL256, KIND_DELTA, KIND_BLACK,
      KIND_BRUN, KIND_RAW
   } kind_type;

   typedef enum logic [2:0] {
      OP_PIXEL = 3'd0, OP_RUN = 3'd1, OP_PALETTE = 3'd2, OP_CLEAR = 3'd3,
      OP_DONE = 3'd4
   } op_type;

   localparam logic [15:0] CT_COLOR256 = 16'd4;
   localparam logic [15:0] CT_COLOR64  = 16'd11;
   localparam logic [15:0] CT_DELTA    = 16'd12;
   localparam logic [15:0] CT_BLACK    = 16'd13;
   localparam logic [15:0] CT_BRUN     = 16'd15;
   localparam logic [15:0] CT_RAW      = 16'd16;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] address;
      logic [15:0] length;
      logic [23:0] value;
      logic        last;
   } rsp_type;

endpackage

@@ rtl/fli_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fli_stream_if
// Valid/ready channel carrying a payload.
// ----------------------------------------------------------------------------
interface fli_stream_if #(parameter type payload_type = logic [7:0]);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/fli_rsp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fli_rsp_queue
// Four-entry response queue; takes up to two responses per cycle.
// ----------------------------------------------------------------------------
module fli_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  fli_pkg::rsp_type     push_a,
   input  fli_pkg::rsp_type     push_b,
   output logic                 space_ok,
   fli_stream_if.source         rsp
);
   fli_pkg::rsp_type mem_ff [4];
   logic [1:0] rd_ff, wr_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop       = rsp.valid && rsp.ready;
   assign rsp.valid = cnt_ff != 3'd0;
   assign rsp.data  = mem_ff[rd_ff];
   assign space_ok  = cnt_ff <= 3'd2;
   assign cnt_in    = cnt_ff + {1'b0, push_count} - {2'b0, pop};

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wr_ff] <= push_a;
      if (push_count == 2'd2) mem_ff[wr_ff + 2'd1] <= push_b;
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_ff + {1'b0, pop};
         wr_ff  <= wr_ff + push_count;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4) else $error("queue overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> cnt_ff <= 3'd2) else $error("push without room");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd0 && !pop |=> $stable(cnt_ff)) else $error("count drift");
endmodule

@@ rtl/fli_frame_chunk_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fli_frame_chunk_decoder
// Frame chunk parser: frame bytes in, draw/palette commands out.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one frame-stream byte per request, starting after the file
//   header. rsp carries commands: pixel write, run fill, palette write,
//   clear and frame done, each with address, length, value and last; last
//   marks the final command caused by one byte (0 to 2 commands per byte).
//   Throughput: one byte per cycle while req_ready is high; the parser is
//   a single registered step per byte. A byte's commands are in the
//   response queue the cycle after acceptance and appear on rsp from
//   there; two commands from one byte leave in order from adjacent entries.
//   When rsp stalls the four-entry queue fills and req_ready drops once
//   fewer than two free slots remain.
//   Reset (synchronous) puts the parser at frame header start and empties
//   the queue.
// ----------------------------------------------------------------------------
module fli_frame_chunk_decoder #(
   parameter int FRAME_WIDTH  = fli_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = fli_pkg::FRAME_HEIGHT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   fli_stream_if.sink    req,
   fli_stream_if.source  rsp
);
   localparam int AREA = FRAME_WIDTH * FRAME_HEIGHT;
   localparam logic [31:0] AREA32 = 32'(AREA);
   localparam logic [31:0] WIDTH32 = 32'(FRAME_WIDTH);
   localparam logic [15:0] HEIGHT16 = 16'(FRAME_HEIGHT);

   fli_pkg::phase_type ph_ff, ph_in;
   fli_pkg::kind_type  kind_ff, kind_in;
   logic [31:0] fleft_ff, fleft_in, cleft_ff, cleft_in, acc_ff, acc_in;
   logic [15:0] chunks_ff, chunks_in, line_ff, line_in, lines_ff, lines_in;
   logic [15:0] pkts_ff, pkts_in, col_ff, col_in, rgb_ff, rgb_in;
   logic [2:0]  fbc_ff, fbc_in;
   logic [16:0] lit_ff, lit_in;
   logic [8:0]  cur_ff, cur_in;
   logic [31:0] addr_row_ff;

   logic        accept, space_ok;
   logic [1:0]  n;
   fli_pkg::rsp_type ra, rb, rnew;
   logic [7:0]  b, ex;
   logic [31:0] acc_new, v, paddr, runlen;
   logic [2:0]  fbc_new;
   logic        chunk_check, body_done;

   assign req.ready = space_ok;
   assign accept    = req.valid && req.ready;
   assign b         = req.data;
   assign acc_new   = acc_ff | ({24'd0, b} << {fbc_ff[1:0], 3'b000});
   assign fbc_new   = fbc_ff + 3'd1;
   assign v         = acc_new;
   assign ex        = (kind_ff == fli_pkg::KIND_COL64) ? ({b[5:0], 2'b00} | {4'd0, b[7:4]})
                                                       : b;
   // row base kept registered: one multiplier off the byte path
   assign paddr     = addr_row_ff + {16'd0, col_ff};
   assign runlen    = ({15'd0, lit_ff} > AREA32 - paddr) ? AREA32 - paddr
                                                        : {15'd0, lit_ff};

   always_ff @(posedge clock) begin
      addr_row_ff <= 32'(line_in) * WIDTH32;
   end

   always_comb begin
      ph_in = ph_ff; kind_in = kind_ff; fleft_in = fleft_ff; cleft_in = cleft_ff;
      acc_in = acc_ff; fbc_in = fbc_ff; chunks_in = chunks_ff; line_in = line_ff;
      lines_in = lines_ff; pkts_in = pkts_ff; col_in = col_ff; lit_in = lit_ff;
      cur_in = cur_ff; rgb_in = rgb_ff;
      n = 2'd0; ra = '0; rb = '0; rnew = '0;
      chunk_check = 1'b0; body_done = 1'b0;
      if (accept) begin
         if (ph_ff >= fli_pkg::PH_FTYPE && fleft_ff != 0) fleft_in = fleft_ff - 32'd1;
         if (ph_ff >= fli_pkg::PH_CTYPE && ph_ff <= fli_pkg::PH_CSKIP) begin
            if (cleft_ff != 0) cleft_in = cleft_ff - 32'd1;
            chunk_check = 1'b1;
         end
         // default: gather field byte
         case (ph_ff)
            fli_pkg::PH_FSIZE, fli_pkg::PH_FTYPE, fli_pkg::PH_FCHUNKS,
            fli_pkg::PH_CSIZE, fli_pkg::PH_CTYPE, fli_pkg::PH_COL_NPKT,
            fli_pkg::PH_DL_START, fli_pkg::PH_DL_NLINES: begin
               acc_in = acc_new; fbc_in = fbc_new;
            end
            default: ;
         endcase
         case (ph_ff)
            fli_pkg::PH_FSIZE: if (fbc_new >= 3'd4) begin
               acc_in = '0; fbc_in = '0;
               fleft_in = (v > 32'd4) ? v - 32'd4 : 32'd0;
               ph_in = fli_pkg::PH_FTYPE;
            end
            fli_pkg::PH_FTYPE: if (fbc_new >= 3'd2) begin
               acc_in = '0; fbc_in = '0; ph_in = fli_pkg::PH_FCHUNKS;
            end
            fli_pkg::PH_FCHUNKS: if (fbc_new >= 3'd2) begin
               acc_in = '0; fbc_in = '0; chunks_in = v[15:0]; ph_in = fli_pkg::PH_FPAD;
            end
            fli_pkg::PH_FPAD: if (fbc_ff >= 3'd7) begin
               fbc_in = '0;
               if (chunks_ff == 0) begin
                  if (fleft_in == 0) begin
                     n = 2'd1; ra.op = fli_pkg::OP_DONE; ph_in = fli_pkg::PH_FSIZE;
                  end else ph_in = fli_pkg::PH_FSKIP;
               end else ph_in = fli_pkg::PH_CSIZE;
            end else fbc_in = fbc_new;
            fli_pkg::PH_CSIZE: if (fbc_new >= 3'd4) begin
               acc_in = '0; fbc_in = '0;
               cleft_in = (v > 32'd4) ? v - 32'd4 : 32'd0;
               ph_in = fli_pkg::PH_CTYPE; chunk_check = 1'b1;
            end
            fli_pkg::PH_CTYPE: if (fbc_new >= 3'd2) begin
               acc_in = '0; fbc_in = '0;
               case (v[15:0])
                  fli_pkg::CT_COLOR256: begin
                     kind_in = fli_pkg::KIND_COL256; ph_in = fli_pkg::PH_COL_NPKT;
                  end
                  fli_pkg::CT_COLOR64: begin
                     kind_in = fli_pkg::KIND_COL64; ph_in = fli_pkg::PH_COL_NPKT;
                  end
                  fli_pkg::CT_DELTA: begin
                     kind_in = fli_pkg::KIND_DELTA; ph_in = fli_pkg::PH_DL_START;
                  end
                  fli_pkg::CT_BLACK: begin
                     kind_in = fli_pkg::KIND_BLACK; body_done = 1'b1;
                     n = 2'd1; ra.op = fli_pkg::OP_CLEAR; ra.length = AREA32[15:0];
                  end
                  fli_pkg::CT_BRUN: begin
                     kind_in = fli_pkg::KIND_BRUN; line_in = '0; lines_in = HEIGHT16;
                     ph_in = fli_pkg::PH_BR_LPKTS; body_done = (HEIGHT16 == 16'd0);
                  end
                  fli_pkg::CT_RAW: begin
                     kind_in = fli_pkg::KIND_RAW; line_in = '0; col_in = '0;
                     ph_in = fli_pkg::PH_RAW;
                  end
                  default: begin
                     kind_in = fli_pkg::KIND_OTHER; body_done = 1'b1;
                  end
               endcase
            end
            fli_pkg::PH_COL_NPKT: if (fbc_new >= 3'd2) begin
               acc_in = '0; fbc_in = '0; pkts_in = v[15:0]; cur_in = '0;
               if (v[15:0] == 0) body_done = 1'b1; else ph_in = fli_pkg::PH_COL_SKIP;
            end
            fli_pkg::PH_COL_SKIP: begin
               cur_in = cur_ff + {1'b0, b}; ph_in = fli_pkg::PH_COL_CNT;
            end
            fli_pkg::PH_COL_CNT: begin
               lit_in = (b == 0) ? 17'd256 : {9'd0, b}; ph_in = fli_pkg::PH_COL_R;
            end
            fli_pkg::PH_COL_R: begin
               rgb_in = {ex, 8'd0}; ph_in = fli_pkg::PH_COL_G;
            end
            fli_pkg::PH_COL_G: begin
               rgb_in = {rgb_ff[15:8], rgb_ff[7:0] | ex}; ph_in = fli_pkg::PH_COL_B;
            end
            fli_pkg::PH_COL_B: begin
               n = 2'd1; ra.op = fli_pkg::OP_PALETTE; ra.address = {8'd0, cur_ff[7:0]};
               ra.value = {rgb_ff, ex};
               cur_in = cur_ff + 9'd1; lit_in = lit_ff - 17'd1;
               if (lit_in != 0) ph_in = fli_pkg::PH_COL_R;
               else begin
                  pkts_in = pkts_ff - 16'd1;
                  if (pkts_in == 0) body_done = 1'b1; else ph_in = fli_pkg::PH_COL_SKIP;
               end
            end
            fli_pkg::PH_DL_START: if (fbc_new >= 3'd2) begin
               acc_in = '0; fbc_in = '0; line_in = v[15:0]; ph_in = fli_pkg::PH_DL_NLINES;
            end
            fli_pkg::PH_DL_NLINES: if (fbc_new >= 3'd2) begin
               acc_in = '0; fbc_in = '0; lines_in = v[15:0];
               if (v[15:0] == 0) body_done = 1'b1; else ph_in = fli_pkg::PH_DL_LPKTS;
            end
            fli_pkg::PH_DL_LPKTS, fli_pkg::PH_BR_LPKTS: begin
               pkts_in = {8'd0, b}; col_in = '0;
               if (b == 0) begin
                  line_in = line_ff + 16'd1; lines_in = lines_ff - 16'd1;
                  if (lines_in == 0) body_done = 1'b1;
               end else ph_in = (ph_ff == fli_pkg::PH_DL_LPKTS) ? fli_pkg::PH_DL_SKIP
                                                                : fli_pkg::PH_BR_COUNT;
            end
            fli_pkg::PH_DL_SKIP: begin
               col_in = col_ff + {8'd0, b}; ph_in = fli_pkg::PH_DL_COUNT;
            end
            fli_pkg::PH_DL_COUNT, fli_pkg::PH_BR_COUNT: begin
               if (b == 0) begin
                  pkts_in = pkts_ff - 16'd1;
                  if (pkts_in == 0) begin
                     line_in = line_ff + 16'd1; lines_in = lines_ff - 16'd1;
                     if (lines_in == 0) body_done = 1'b1;
                     else ph_in = (ph_ff == fli_pkg::PH_DL_COUNT) ? fli_pkg::PH_DL_LPKTS
                                                                  : fli_pkg::PH_BR_LPKTS;
                  end else ph_in = (ph_ff == fli_pkg::PH_DL_COUNT) ? fli_pkg::PH_DL_SKIP
                                                                   : fli_pkg::PH_BR_COUNT;
               end else if (b < 8'd128) begin
                  lit_in = {9'd0, b};
                  ph_in = (ph_ff == fli_pkg::PH_DL_COUNT) ? fli_pkg::PH_DL_LIT
                                                          : fli_pkg::PH_BR_COLOR;
               end else begin
                  lit_in = 17'd256 - {9'd0, b};
                  ph_in = (ph_ff == fli_pkg::PH_DL_COUNT) ? fli_pkg::PH_DL_COLOR
                                                          : fli_pkg::PH_BR_LIT;
               end
            end
            fli_pkg::PH_DL_LIT, fli_pkg::PH_BR_LIT, fli_pkg::PH_DL_COLOR,
            fli_pkg::PH_BR_COLOR: begin
               if (ph_ff == fli_pkg::PH_DL_LIT || ph_ff == fli_pkg::PH_BR_LIT) begin
                  if (paddr < AREA32) begin
                     n = 2'd1; ra.op = fli_pkg::OP_PIXEL; ra.address = paddr[15:0];
                     ra.value = {16'd0, b};
                  end
                  col_in = col_ff + 16'd1; lit_in = lit_ff - 17'd1;
               end else begin
                  if (paddr < AREA32) begin
                     n = 2'd1; ra.op = fli_pkg::OP_RUN; ra.address = paddr[15:0];
                     ra.length = runlen[15:0]; ra.value = {16'd0, b};
                  end
                  col_in = col_ff + lit_ff[15:0]; lit_in = '0;
               end
               if (lit_in == 0) begin
                  pkts_in = pkts_ff - 16'd1;
                  if (pkts_in == 0) begin
                     line_in = line_ff + 16'd1; lines_in = lines_ff - 16'd1;
                     if (lines_in == 0) body_done = 1'b1;
                     else ph_in = (kind_ff == fli_pkg::KIND_DELTA) ? fli_pkg::PH_DL_LPKTS
                                                                   : fli_pkg::PH_BR_LPKTS;
                  end else ph_in = (kind_ff == fli_pkg::KIND_DELTA) ? fli_pkg::PH_DL_SKIP
                                                                    : fli_pkg::PH_BR_COUNT;
               end
            end
            fli_pkg::PH_RAW: begin
               if (paddr < AREA32) begin
                  n = 2'd1; ra.op = fli_pkg::OP_PIXEL; ra.address = paddr[15:0];
                  ra.value = {16'd0, b};
               end
               col_in = col_ff + 16'd1;
               if ({16'd0, col_in} >= WIDTH32) begin
                  col_in = '0; line_in = line_ff + 16'd1;
                  if (line_in >= HEIGHT16) body_done = 1'b1;
               end
            end
            fli_pkg::PH_CSKIP: ;
            fli_pkg::PH_FSKIP: if (fleft_in == 0) begin
               n = 2'd1; ra.op = fli_pkg::OP_DONE; ph_in = fli_pkg::PH_FSIZE;
            end
            default: ph_in = fli_pkg::PH_FSIZE;
         endcase
         if (chunk_check) begin
            if (cleft_in == 0) begin
               acc_in = '0; fbc_in = '0; chunks_in = chunks_ff - 16'd1;
               if (chunks_in != 0) ph_in = fli_pkg::PH_CSIZE;
               else if (fleft_in == 0) begin
                  rnew.op = fli_pkg::OP_DONE;
                  if (n == 2'd0) begin ra = rnew; n = 2'd1; end
                  else begin rb = rnew; n = 2'd2; end
                  ph_in = fli_pkg::PH_FSIZE;
               end else ph_in = fli_pkg::PH_FSKIP;
            end else if (body_done) ph_in = fli_pkg::PH_CSKIP;
         end
         if (n == 2'd1) ra.last = 1'b1;
         if (n == 2'd2) rb.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= fli_pkg::PH_FSIZE; kind_ff <= fli_pkg::KIND_OTHER;
         fleft_ff <= '0; cleft_ff <= '0; acc_ff <= '0; fbc_ff <= '0;
         chunks_ff <= '0; line_ff <= '0; lines_ff <= '0; pkts_ff <= '0;
         col_ff <= '0; lit_ff <= '0; cur_ff <= '0; rgb_ff <= '0;
      end else begin
         ph_ff <= ph_in; kind_ff <= kind_in; fleft_ff <= fleft_in;
         cleft_ff <= cleft_in; acc_ff <= acc_in; fbc_ff <= fbc_in;
         chunks_ff <= chunks_in; line_ff <= line_in; lines_ff <= lines_in;
         pkts_ff <= pkts_in; col_ff <= col_in; lit_ff <= lit_in;
         cur_ff <= cur_in; rgb_ff <= rgb_in;
      end
   end

   fli_rsp_queue u_queue (
      .clock(clock), .reset(reset), .push_count(n), .push_a(ra), .push_b(rb),
      .space_ok(space_ok), .rsp(rsp)
   );

   a_idle_no_push: assert property (@(posedge clock) disable iff (reset)
      !accept |-> n == 2'd0) else $error("output without request");
   a_fsize_to_ftype: assert property (@(posedge clock) disable iff (reset)
      accept && ph_ff == fli_pkg::PH_FSIZE && fbc_ff == 3'd3 |=> ph_ff == fli_pkg::PH_FTYPE)
      else $error("frame size not taken");
   a_lit_range: assert property (@(posedge clock) disable iff (reset)
      lit_ff <= 17'd256) else $error("literal count out of range");
endmodule
